[rtl/core/assert_macros.svh]
// Assertion macros shared by the list core RTL.
// Defining NO_ASSERTIONS removes every check; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked property, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Clocked property that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[rtl/core/cil_pkg.sv]
// Package for the compacting indexed list: codes, field widths and the cell command.
// Used by the interfaces, the cell and the top level; depends on nothing.
`default_nettype none
package cil_pkg;
   localparam int CAPACITY_DEF   = 64;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int ACTION_W       = 2;
   localparam int IDX_W          = 6;
   localparam int VALUE_W        = 32;
   localparam int COUNT_W        = 7;
   localparam int STATUS_W       = 2;
   localparam int WIDE_W         = 64;

   typedef enum logic [ACTION_W-1:0] {
      ACT_APPEND = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_READ   = 2'd2,
      ACT_WRITE  = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Broadcast from the top level to every cell at once.
   typedef struct packed {
      logic             append_en;
      logic             write_en;
      logic             remove_en;
      logic [IDX_W-1:0] index;
   } cmd_type;
endpackage
`default_nettype wire

[rtl/core/cil_if.sv]
// Valid/ready channel interfaces for the list requests and results.
// Field widths come from cil_pkg.
`default_nettype none
interface cil_req_if;
   logic                        valid;
   logic                        ready;
   logic [cil_pkg::ACTION_W-1:0] action;
   logic [cil_pkg::IDX_W-1:0]    index;
   logic [cil_pkg::VALUE_W-1:0]  value;
   modport source (output valid, output action, output index, output value, input ready);
   modport sink   (input valid, input action, input index, input value, output ready);
endinterface

interface cil_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [cil_pkg::VALUE_W-1:0]  read_value;
   logic [cil_pkg::COUNT_W-1:0]  count;
   logic [cil_pkg::STATUS_W-1:0] status;
   modport source (output valid, output read_value, output count, output status, input ready);
   modport sink   (input valid, input read_value, input count, input status, output ready);
endinterface
`default_nettype wire

[rtl/core/cil_cell.sv]
// One storage cell of the list: holds the entry at position POS.
// Takes its neighbor's word on a remove at or below POS; uses cil_pkg.
`default_nettype none
module cil_cell #(
   parameter int DATA_WIDTH = cil_pkg::DATA_WIDTH_DEF,
   parameter int POS        = 0,
   parameter int CNT_W      = 7
) (
   input  wire logic                  clock,
   input  wire cil_pkg::cmd_type      cmd,
   input  wire logic [CNT_W-1:0]      tail,
   input  wire logic [DATA_WIDTH-1:0] value,
   input  wire logic [DATA_WIDTH-1:0] next_data,
   output logic      [DATA_WIDTH-1:0] data,
   output logic      [DATA_WIDTH-1:0] rd_data
);
   localparam int CMP_W = ((CNT_W > cil_pkg::IDX_W) ? CNT_W : cil_pkg::IDX_W) + 1;
   localparam logic [CMP_W-1:0] POS_C = CMP_W'(POS);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic [CMP_W-1:0]      idx_c;
   logic [CMP_W-1:0]      tail_c;
   logic                  idx_hit;

   assign idx_c   = CMP_W'(cmd.index);
   assign tail_c  = CMP_W'(tail);
   assign idx_hit = (POS_C == idx_c);

   always_comb begin
      data_in = data_ff;
      if (cmd.append_en && (POS_C == tail_c)) begin
         data_in = value;
      end else if (cmd.write_en && idx_hit) begin
         data_in = value;
      end else if (cmd.remove_en && (POS_C >= idx_c)) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   assign rd_data = idx_hit ? data_ff : '0;
endmodule
`default_nettype wire

[rtl/core/compacting_indexed_list.sv]
// Top level of the compacting indexed list: request decode, live count and result register.
// Instantiates a row of cil_cell; uses cil_pkg, cil_req_if, cil_rsp_if and assert_macros.svh.
//
// Use: each transfer on req_ch carries an action (append, remove at index, read at index,
// write at index), an index and a data word. Each request produces exactly one transfer on
// rsp_ch with the read word (zero unless a read succeeds), the live count after the request
// and a status: ok, index out of range, or list full on an append.
// Result: registered, and valid in the cycle after the request transfer.
// Throughput: one request per cycle while rsp_ch.ready is high. Every cell updates in the
// same cycle, so a remove shifts all later entries down by one position at once; the
// read is an OR over the cells' gated outputs; the live count and entries are the state.
// Stalls: the result sits in an output register; req_ch.ready stays high while that
// register is empty or is being drained, and drops while a result waits on a low
// rsp_ch.ready, so nothing is lost or repeated.
// Reset: synchronous, active high; it empties the list and the result register. Entry
// storage is not cleared, since only appended positions can ever be read.
`default_nettype none
`include "assert_macros.svh"
module compacting_indexed_list_core #(
   parameter int CAPACITY   = cil_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = cil_pkg::DATA_WIDTH_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   cil_req_if.sink   req_ch,
   cil_rsp_if.source rsp_ch
);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > cil_pkg::IDX_W) ? CNT_W : cil_pkg::IDX_W) + 1;
   localparam logic [CNT_W-1:0] FULL_C = CNT_W'(CAPACITY);

   logic [CNT_W-1:0]                count_ff;
   logic [CNT_W-1:0]                count_in;
   logic                            rsp_valid_ff;
   logic [cil_pkg::VALUE_W-1:0]      read_value_ff;
   logic [cil_pkg::VALUE_W-1:0]      read_value_in;
   logic [cil_pkg::COUNT_W-1:0]      rsp_count_ff;
   logic [cil_pkg::COUNT_W-1:0]      rsp_count_in;
   cil_pkg::status_type              status_ff;
   cil_pkg::status_type              status_in;

   cil_pkg::action_type              action;
   cil_pkg::cmd_type                 cmd;
   logic                            accept;
   logic                            full;
   logic                            in_range;
   logic [cil_pkg::WIDE_W-1:0]       value_wide;
   logic [DATA_WIDTH-1:0]           value_st;
   logic [DATA_WIDTH-1:0]           rd_or;
   logic [cil_pkg::WIDE_W-1:0]       rd_wide;
   logic [cil_pkg::WIDE_W-1:0]       count_wide;

   logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
   logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];

   assign action       = cil_pkg::action_type'(req_ch.action);
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign full         = (count_ff == FULL_C);
   assign in_range     = (CMP_W'(req_ch.index) < CMP_W'(count_ff));
   assign value_wide   = cil_pkg::WIDE_W'(req_ch.value);
   assign value_st     = value_wide[DATA_WIDTH-1:0];

   always_comb begin
      cmd.index     = req_ch.index;
      cmd.append_en = accept && (action == cil_pkg::ACT_APPEND) && !full;
      cmd.write_en  = accept && (action == cil_pkg::ACT_WRITE) && in_range;
      cmd.remove_en = accept && (action == cil_pkg::ACT_REMOVE) && in_range;
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic [DATA_WIDTH-1:0] nbr;
         if (g == CAPACITY - 1) begin : g_last
            assign nbr = '0;
         end else begin : g_mid
            assign nbr = cell_data[g+1];
         end
         cil_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .POS        (g),
            .CNT_W      (CNT_W)
         ) u_cell (
            .clock     (clock),
            .cmd       (cmd),
            .tail      (count_ff),
            .value     (value_st),
            .next_data (nbr),
            .data      (cell_data[g]),
            .rd_data   (cell_rd[g])
         );
      end
   endgenerate

   // At most one cell matches the index, so an OR of the gated outputs selects it.
   always_comb begin
      rd_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_or = rd_or | cell_rd[i];
      end
   end

   assign rd_wide = cil_pkg::WIDE_W'(rd_or);

   always_comb begin
      count_in      = count_ff;
      status_in     = cil_pkg::ST_OK;
      read_value_in = '0;
      case (action)
         cil_pkg::ACT_APPEND: begin
            if (full) begin
               status_in = cil_pkg::ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         cil_pkg::ACT_REMOVE: begin
            if (!in_range) begin
               status_in = cil_pkg::ST_RANGE;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         cil_pkg::ACT_READ: begin
            if (!in_range) begin
               status_in = cil_pkg::ST_RANGE;
            end else begin
               read_value_in = rd_wide[cil_pkg::VALUE_W-1:0];
            end
         end
         cil_pkg::ACT_WRITE: begin
            if (!in_range) begin
               status_in = cil_pkg::ST_RANGE;
            end
         end
         default: begin
            status_in = cil_pkg::ST_OK;
         end
      endcase
   end

   assign count_wide   = cil_pkg::WIDE_W'(count_in);
   assign rsp_count_in = count_wide[cil_pkg::COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_value_ff <= read_value_in;
         rsp_count_ff  <= rsp_count_in;
         status_ff     <= status_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_value = read_value_ff;
   assign rsp_ch.count      = rsp_count_ff;
   assign rsp_ch.status     = status_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset || (count_ff <= FULL_C))
   `ASSERT_CLK(a_append_grows, clock, reset,
      cmd.append_en |=> count_ff == $past(count_ff) + CNT_W'(1))
   `ASSERT_CLK(a_full_at_cap, clock, reset,
      (rsp_valid_ff && status_ff == cil_pkg::ST_FULL) |-> count_ff == FULL_C)
   `ASSERT_CLK(a_fail_reads_zero, clock, reset,
      (rsp_valid_ff && status_ff != cil_pkg::ST_OK) |-> read_value_ff == '0)
endmodule
`default_nettype wire
